FILE: rtl/core/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg: shared types and constants for the gamepad poll-to-HID block
// Poll phase encoding, register indexes, report field constants and the
// structs passed between the poll sequencer and the report stage.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

    // Poll sequencer phases
    typedef enum logic [1:0] {
        PH_GAP   = 2'd0,
        PH_LATCH = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } poll_phase_t;

    // Configuration register indexes
    localparam logic [1:0] REG_LATCH_TICKS = 2'd0;
    localparam logic [1:0] REG_HALF_TICKS  = 2'd1;
    localparam logic [1:0] REG_GAP_TICKS   = 2'd2;

    // Register reset values
    localparam logic [7:0]  LATCH_TICKS_RST = 8'd12;
    localparam logic [7:0]  HALF_TICKS_RST  = 8'd6;
    localparam logic [15:0] GAP_TICKS_RST   = 16'd0;

    // Serial frame
    localparam logic [4:0] FRAME_BITS = 5'd16;
    localparam logic [4:0] BYTE_BITS  = 5'd8;

    // First byte direction bits
    localparam logic [7:0] BTN_RIGHT = 8'h01;
    localparam logic [7:0] BTN_LEFT  = 8'h02;
    localparam logic [7:0] BTN_DOWN  = 8'h04;
    localparam logic [7:0] BTN_UP    = 8'h08;
    localparam logic [7:0] BTN_HIGH  = 8'hF0;

    // Axis values
    localparam logic [7:0] AXIS_MIN    = 8'd0;
    localparam logic [7:0] AXIS_CENTER = 8'd128;
    localparam logic [7:0] AXIS_MAX    = 8'd255;

    // Pin levels and read bytes for the tick being processed
    typedef struct packed {
        logic        latch_line;
        logic        clock_line;
        logic [15:0] read_bytes;
    } poll_stat_t;

    // One result item
    typedef struct packed {
        logic       latch_line;
        logic       clock_line;
        logic       report_valid;
        logic [7:0] axis_x;
        logic [7:0] axis_y;
        logic [7:0] button_bits;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/gsp_if.sv
// ----------------------------------------------------------------------------
// gsp_tick_if / gsp_result_if: valid/ready channels of the poll block
// The tick channel carries sampled pin and host flags; the result channel
// carries pin levels and the HID report for the tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsp_tick_if;
    logic valid;
    logic ready;
    logic data_pin;
    logic host_ready;
    logic report_request;

    modport source (output valid, output data_pin, output host_ready,
                    output report_request, input ready);
    modport sink (input valid, input data_pin, input host_ready,
                  input report_request, output ready);
endinterface

interface gsp_result_if;
    logic       valid;
    logic       ready;
    logic       latch_line;
    logic       clock_line;
    logic       report_valid;
    logic [7:0] axis_x;
    logic [7:0] axis_y;
    logic [7:0] button_bits;

    modport source (output valid, output latch_line, output clock_line,
                    output report_valid, output axis_x, output axis_y,
                    output button_bits, input ready);
    modport sink (input valid, input latch_line, input clock_line,
                  input report_valid, input axis_x, input axis_y,
                  input button_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gsp_poll.sv
// ----------------------------------------------------------------------------
// gsp_poll: latch/clock sequencer and serial shift register
// Steps the poll phase once per accepted tick, drives the pin levels and
// shifts in the inverted data bit on each falling clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_poll (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              data_pin,
    input  wire logic [7:0]        latch_ticks,
    input  wire logic [7:0]        half_ticks,
    input  wire logic [15:0]       gap_ticks,
    output gsp_pkg::poll_stat_t    stat
);
    import gsp_pkg::*;

    poll_phase_t phase_reg, phase_next, phase_cur;
    logic [15:0] tick_count_reg, tick_count_next, tick_cur, tick_inc;
    logic [4:0]  bits_left_reg, bits_left_next, bits_dec;
    logic [7:0]  shift_byte_reg, shift_byte_next, shift_in;
    logic [15:0] read_bytes_reg, read_bytes_next;
    logic        sample;
    logic        half_done;

    // Gap expiry: the latch starts on this same tick
    always_comb
    begin
        phase_cur = phase_reg;
        tick_cur  = tick_count_reg;
        if (phase_reg == PH_GAP && tick_count_reg >= gap_ticks)
        begin
            phase_cur = PH_LATCH;
            tick_cur  = '0;
        end
    end

    // Pin levels and falling-edge sampling
    always_comb
    begin
        stat.latch_line = (phase_cur == PH_LATCH);
        stat.clock_line = (phase_cur != PH_LOW);
        sample   = (phase_cur == PH_LOW) && (tick_cur == '0) && (bits_left_reg != '0);
        shift_in = {shift_byte_reg[6:0], ~data_pin};
        bits_dec = bits_left_reg - 5'd1;
        read_bytes_next = read_bytes_reg;
        if (sample && bits_dec == BYTE_BITS)
            read_bytes_next[15:8] = shift_in;
        else if (sample && bits_dec == '0)
            read_bytes_next[7:0] = shift_in;
        stat.read_bytes = read_bytes_next;
    end

    // Next phase and counters
    always_comb
    begin
        tick_inc        = tick_cur + 16'd1;
        half_done       = (tick_inc >= {8'd0, half_ticks});
        phase_next      = phase_cur;
        tick_count_next = tick_inc;
        bits_left_next  = sample ? bits_dec : bits_left_reg;
        shift_byte_next = sample ? shift_in : shift_byte_reg;
        unique case (phase_cur)
            PH_LATCH:
            begin
                if (tick_inc >= {8'd0, latch_ticks})
                begin
                    phase_next      = PH_HIGH;
                    tick_count_next = '0;
                    bits_left_next  = FRAME_BITS;
                    shift_byte_next = '0;
                end
            end
            PH_HIGH:
            begin
                if (half_done)
                begin
                    phase_next      = PH_LOW;
                    tick_count_next = '0;
                end
            end
            PH_LOW:
            begin
                if (half_done)
                begin
                    phase_next      = (bits_left_next == '0) ? PH_GAP : PH_HIGH;
                    tick_count_next = '0;
                end
            end
            default:
            begin
                phase_next = phase_cur;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_GAP;
            tick_count_reg <= '0;
            bits_left_reg  <= FRAME_BITS;
            shift_byte_reg <= '0;
            read_bytes_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            bits_left_reg  <= bits_left_next;
            shift_byte_reg <= shift_byte_next;
            read_bytes_reg <= read_bytes_next;
        end
    end

    // Bit counter never exceeds one frame
    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= FRAME_BITS)
        else $error("gsp_poll: bit counter out of range");

    // Between polls the frame is either complete or not yet started
    a_gap_bits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GAP |-> (bits_left_reg == '0 || bits_left_reg == FRAME_BITS))
        else $error("gsp_poll: gap entered mid-frame");

    // Latch and clock phases are bounded by 8-bit registers
    a_tick_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_GAP |-> tick_count_reg[15:8] == '0)
        else $error("gsp_poll: phase tick count overran");

endmodule

`default_nettype wire

FILE: rtl/core/gsp_report.sv
// ----------------------------------------------------------------------------
// gsp_report: HID report decision, formatting and result register
// Decides on change or request, maps the read bytes to axes and buttons,
// and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gsp_report (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire gsp_pkg::poll_stat_t stat,
    input  wire logic              host_ready,
    input  wire logic              report_request,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output gsp_pkg::result_t       res
);
    import gsp_pkg::*;

    logic [15:0] reported_bytes_reg;
    logic        out_valid_reg;
    result_t     res_reg, res_next;
    logic        fire;
    logic [7:0]  b1, b2;

    // Report decision and field mapping
    always_comb
    begin
        b1   = stat.read_bytes[15:8];
        b2   = stat.read_bytes[7:0];
        fire = (host_ready && stat.read_bytes != reported_bytes_reg) || report_request;
        res_next.latch_line   = stat.latch_line;
        res_next.clock_line   = stat.clock_line;
        res_next.report_valid = fire;
        res_next.axis_x       = '0;
        res_next.axis_y       = '0;
        res_next.button_bits  = '0;
        if (fire)
        begin
            // left wins over right, up wins over down
            if ((b1 & BTN_LEFT) != '0)
                res_next.axis_x = AXIS_MIN;
            else if ((b1 & BTN_RIGHT) != '0)
                res_next.axis_x = AXIS_MAX;
            else
                res_next.axis_x = AXIS_CENTER;
            if ((b1 & BTN_UP) != '0)
                res_next.axis_y = AXIS_MIN;
            else if ((b1 & BTN_DOWN) != '0)
                res_next.axis_y = AXIS_MAX;
            else
                res_next.axis_y = AXIS_CENTER;
            res_next.button_bits = (b1 & BTN_HIGH) | {4'd0, b2[7:4]};
        end
    end

    // Last reported bytes and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reported_bytes_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance && fire)
                reported_bytes_reg <= stat.read_bytes;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // Without a report the report fields read zero
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.report_valid |->
            (res_reg.axis_x == '0 && res_reg.axis_y == '0 && res_reg.button_bits == '0))
        else $error("gsp_report: report fields set without a report");

    // A change report leaves nothing pending for the next tick
    a_caught_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && fire |=> reported_bytes_reg == $past(stat.read_bytes))
        else $error("gsp_report: reported bytes not updated");

endmodule

`default_nettype wire

FILE: rtl/core/gamepad_serial_poll_to_hid.sv
// ----------------------------------------------------------------------------
// gamepad_serial_poll_to_hid: latch/clock gamepad reader to HID report
// Top level: configuration registers, tick handshake, poll and report stages.
// ----------------------------------------------------------------------------
// Each tick request carries the sampled controller data pin and the host
// flags; each one yields exactly one result request with the latch and clock
// pin levels for that tick and, when the host is ready and the buttons
// changed or a report was requested, a 3-byte HID report (axes and eight
// buttons). One tick is taken per clock cycle unless the result stalls: the
// whole tick is evaluated in a single pass into the result register, and a
// new tick is accepted while the previous result waits as long as the result
// register is being emptied in the same cycle. Configuration registers are
// written through cfg_we, cfg_index and cfg_data; other indexes are ignored.
`default_nettype none

module gamepad_serial_poll_to_hid (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gsp_tick_if.sink         tick,
    gsp_result_if.source     result,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import gsp_pkg::*;

    logic [7:0]  latch_ticks_reg;
    logic [7:0]  half_ticks_reg;
    logic [15:0] gap_ticks_reg;
    logic        advance;
    logic        out_valid;
    poll_stat_t  stat;
    result_t     res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_ticks_reg <= LATCH_TICKS_RST;
            half_ticks_reg  <= HALF_TICKS_RST;
            gap_ticks_reg   <= GAP_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LATCH_TICKS: latch_ticks_reg <= cfg_data[7:0];
                REG_HALF_TICKS:  half_ticks_reg  <= cfg_data[7:0];
                REG_GAP_TICKS:   gap_ticks_reg   <= cfg_data;
                default:         latch_ticks_reg <= latch_ticks_reg;
            endcase
        end
    end

    // Tick handshake: take a tick whenever the result register frees up
    assign tick.ready = !out_valid || result.ready;
    assign advance    = tick.valid && tick.ready;

    gsp_poll u_poll (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_pin    (tick.data_pin),
        .latch_ticks (latch_ticks_reg),
        .half_ticks  (half_ticks_reg),
        .gap_ticks   (gap_ticks_reg),
        .stat        (stat)
    );

    gsp_report u_report (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .stat           (stat),
        .host_ready     (tick.host_ready),
        .report_request (tick.report_request),
        .out_ready      (result.ready),
        .out_valid      (out_valid),
        .res            (res)
    );

    // Result channel
    assign result.valid        = out_valid;
    assign result.latch_line   = res.latch_line;
    assign result.clock_line   = res.clock_line;
    assign result.report_valid = res.report_valid;
    assign result.axis_x       = res.axis_x;
    assign result.axis_y       = res.axis_y;
    assign result.button_bits  = res.button_bits;

    // Every accepted tick leaves a result pending next cycle
    a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result.valid)
        else $error("gamepad_serial_poll_to_hid: accepted tick produced no result");

    // A stalled result blocks further ticks
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |-> !tick.ready)
        else $error("gamepad_serial_poll_to_hid: tick taken over a stalled result");

endmodule

`default_nettype wire
